// ===== rtl/rkst_pkg.sv =====
// ----------------------------------------------------------------------------
// rkst_pkg
// Shared types and constants for the reference-counted key slot table.
// ----------------------------------------------------------------------------
package rkst_pkg;

    localparam int CAPACITY   = 256;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int USED_BITS  = $clog2(CAPACITY + 1);

    localparam logic [31:0]           EMPTY_KEY = 32'hFFFF_FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [2:0] RS_DONE   = 3'd0;
    localparam logic [2:0] RS_NEW    = 3'd1;
    localparam logic [2:0] RS_FREED  = 3'd2;
    localparam logic [2:0] RS_BADKEY = 3'd3;
    localparam logic [2:0] RS_FULL   = 3'd4;
    localparam logic [2:0] RS_BADIDX = 3'd5;
    localparam logic [2:0] RS_SAT    = 3'd6;

    typedef struct packed {
        logic [1:0]          command;
        logic [31:0]         key;
        logic [IDX_BITS-1:0] slot;
    } req_item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]   slot_out;
        logic [31:0]           key_out;
        logic [COUNT_BITS-1:0] ref_count;
        logic [2:0]            status;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_EXEC
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic commit;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic                 scan_needed;
        logic                 scan_last;
        logic                 out_free;
        logic [USED_BITS-1:0] used_slots;
    } ctl_stat_t;

endpackage

// ===== rtl/refcounted_key_slot_table.sv =====
// ----------------------------------------------------------------------------
// refcounted_key_slot_table
// Table of keyed slots with reference counts: add by key, remove and query
// by slot index.
// ----------------------------------------------------------------------------
//   channel | signals                  | payload
//   --------+--------------------------+------------------------------------
//   request | req_valid / req_ready    | req : command, key, slot
//   result  | rsp_valid / rsp_ready    | rsp : slot_out, key_out, ref_count,
//           |                          |       status
//
// Add with a good key scans the whole table, also when the table
// turns out full: one table read per slot through the single key memory
// read port, then a drain, a fetch and a commit.
// Remove, query and adds with a bad key skip the scan: a fetch and a commit.
// One item is in flight at a time; the result register lets the next item
// be taken while a result waits. A stalled result holds the commit step.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_key_slot_table
    import rkst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    rkst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rkst_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // a commit never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid || rsp_ready))
        else $error("result overwritten before it was taken");

    // one item at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("item accepted while another is in flight");

    // occupancy changes only when an item commits
    a_used_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(stat.used_slots))
        else $error("used slot count changed without a commit");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.used_slots <= USED_BITS'(CAPACITY))
        else $error("used slot count above capacity");

    // a scan step never coincides with an accept or a commit
    a_scan_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_step && (cmd.commit || cmd.accept)))
        else $error("scan overlaps accept or commit");

endmodule

// ===== rtl/rkst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rkst_ctrl
// Sequencer: accept, key scan, table read, commit of one item at a time.
// ----------------------------------------------------------------------------
module rkst_ctrl
    import rkst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.scan_needed ? S_SCAN : S_FETCH;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_FETCH;
            S_FETCH: state_next = S_EXEC;
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd.accept    = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            S_SCAN:  cmd.scan_step = 1'b1;
            S_EXEC:  cmd.commit    = stat.out_free;
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/rkst_dpath.sv =====
// ----------------------------------------------------------------------------
// rkst_dpath
// Slot storage, scan compare, update logic and result register.
// ----------------------------------------------------------------------------
module rkst_dpath
    import rkst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req,
    input  ctl_cmd_t  cmd,
    output ctl_stat_t stat,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    // slot storage; an entry is meaningful only while its valid bit is set
    logic [31:0]           key_mem [CAPACITY];
    logic [COUNT_BITS-1:0] cnt_mem [CAPACITY];
    logic [CAPACITY-1:0]   vld_reg;

    req_item_t             item_reg;
    logic [IDX_BITS-1:0]   scan_ctr_reg;
    logic                  cmp_en_reg;
    logic [IDX_BITS-1:0]   cmp_idx_reg;
    logic                  hit_found_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg;
    logic                  free_found_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;
    logic [USED_BITS-1:0]  used_reg;
    logic [USED_BITS-1:0]  used_next;

    logic [31:0]           key_rd_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic                  vld_rd_reg;

    logic                  rsp_valid_reg;
    rsp_item_t             rsp_reg;

    logic [IDX_BITS-1:0]   rd_addr;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [31:0]           wr_key;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic                  wr_en;
    logic                  set_vld;
    logic                  clr_vld;
    logic                  mem_we;
    logic                  key_bad;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;
    rsp_item_t             res;

    assign stat.scan_needed = (req.command == CMD_ADD) && (req.key != 32'd0) &&
                              (req.key != EMPTY_KEY);
    assign stat.scan_last   = (scan_ctr_reg == IDX_BITS'(CAPACITY - 1));
    assign stat.out_free    = !rsp_valid_reg || rsp_ready;
    assign stat.used_slots  = used_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // read port: scan walks the table, otherwise the target slot
    assign rd_addr = cmd.scan_step ? scan_ctr_reg :
                     (hit_found_reg ? hit_idx_reg : item_reg.slot);

    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[rd_addr];
        cnt_rd_reg <= cnt_mem[rd_addr];
        vld_rd_reg <= vld_reg[rd_addr];
        if (mem_we)
        begin
            key_mem[wr_addr] <= wr_key;
            cnt_mem[wr_addr] <= wr_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_ctr_reg;
        if (cmd.accept)
        begin
            item_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= res;
        end
    end

    // scan compare works on the read data in the cycle after its read address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_ctr_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg    <= '0;
            free_idx_reg   <= '0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan_step;
            if (cmd.accept)
            begin
                scan_ctr_reg   <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_ctr_reg <= scan_ctr_reg + 1'b1;
                end
                if (cmp_en_reg)
                begin
                    if (!hit_found_reg && vld_rd_reg && (key_rd_reg == item_reg.key))
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= cmp_idx_reg;
                    end
                    if (!free_found_reg && !vld_rd_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                end
            end
        end
    end

    assign key_bad = (item_reg.key == 32'd0) || (item_reg.key == EMPTY_KEY);
    assign cnt_inc = cnt_rd_reg + 1'b1;
    assign cnt_dec = cnt_rd_reg - 1'b1;

    always_comb
    begin
        res       = '{slot_out: item_reg.slot, key_out: EMPTY_KEY,
                      ref_count: '0, status: RS_BADIDX};
        wr_en     = 1'b0;
        wr_addr   = item_reg.slot;
        wr_key    = key_rd_reg;
        wr_cnt    = cnt_rd_reg;
        set_vld   = 1'b0;
        clr_vld   = 1'b0;
        case (item_reg.command)
            CMD_ADD:
            begin
                if (key_bad)
                begin
                    res.status = RS_BADKEY;
                end
                else if (hit_found_reg)
                begin
                    res.slot_out = hit_idx_reg;
                    res.key_out  = item_reg.key;
                    if (cnt_rd_reg == COUNT_MAX)
                    begin
                        res.ref_count = cnt_rd_reg;
                        res.status    = RS_SAT;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = hit_idx_reg;
                        wr_key        = item_reg.key;
                        wr_cnt        = cnt_inc;
                        res.ref_count = cnt_inc;
                        res.status    = RS_DONE;
                    end
                end
                else if (free_found_reg)
                begin
                    wr_en         = 1'b1;
                    set_vld       = 1'b1;
                    wr_addr       = free_idx_reg;
                    wr_key        = item_reg.key;
                    wr_cnt        = COUNT_BITS'(1);
                    res.slot_out  = free_idx_reg;
                    res.key_out   = item_reg.key;
                    res.ref_count = COUNT_BITS'(1);
                    res.status    = RS_NEW;
                end
                else
                begin
                    res.status = RS_FULL;
                end
            end
            CMD_REMOVE:
            begin
                if (vld_rd_reg)
                begin
                    res.key_out = key_rd_reg;
                    if (cnt_dec == '0)
                    begin
                        clr_vld       = 1'b1;
                        res.ref_count = '0;
                        res.status    = RS_FREED;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_cnt        = cnt_dec;
                        res.ref_count = cnt_dec;
                        res.status    = RS_DONE;
                    end
                end
            end
            CMD_QUERY:
            begin
                if (vld_rd_reg)
                begin
                    res.key_out   = key_rd_reg;
                    res.ref_count = cnt_rd_reg;
                    res.status    = RS_DONE;
                end
            end
            default:
            begin
                res.status = RS_BADIDX;
            end
        endcase
    end

    assign mem_we = cmd.commit && wr_en;

    always_comb
    begin
        used_next = used_reg;
        if (set_vld)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (clr_vld && (used_reg != '0))
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                used_reg <= used_next;
                if (set_vld)
                begin
                    vld_reg[wr_addr] <= 1'b1;
                end
                if (clr_vld)
                begin
                    vld_reg[wr_addr] <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule
